>>> hw/rtl/swap_slot_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// swap slot allocator assertion macros
// shared property forms used by the rtl checks
// ----------------------------------------------------------------------------
`ifndef SWAP_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define SWAP_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define SSA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is held
`define SSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg
// shared constants and types of the swap slot allocator
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int SLOT_COUNT_DEF = 2048;

    localparam int WORD_W       = 32;  // bitmap bits per memory word
    localparam int BIT_W        = 5;   // bit index within a word
    localparam int CFG_W        = 11;  // width of the window registers
    localparam int CFG_IDX_W    = 1;
    localparam int SLOT_FIELD_W = 11;
    localparam int STATUS_W     = 3;
    localparam int ENTRY_W      = 32;
    localparam int PAGE_LSB     = 12;  // page frame / slot field starts here
    localparam int ENTRY_SLOT_W = ENTRY_W - PAGE_LSB;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST = 1'b1;

    localparam logic [CFG_W-1:0] LOWEST_RST  = 11'd0;
    localparam logic [CFG_W-1:0] HIGHEST_RST = 11'd2047;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ALLOCATED = 3'd0,
        STAT_NO_PAGE   = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_FREED     = 3'd3,
        STAT_RANGE     = 3'd4
    } status_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_idx;
    } ffz_res_t;

endpackage

>>> hw/rtl/swap_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// swap_slot_allocator_top
// first-fit swap slot allocator over a bitmap held in block ram
// ----------------------------------------------------------------------------
// usage
//   request channel s_valid/s_ready carries s_op and s_entry_word. op allocate
//   takes the lowest free slot in [lowest_slot, highest_slot], op free clears
//   the slot in entry bits 31..12. results leave on m_valid/m_ready as
//   m_slot and m_status, one per request, in order.
//   cfg_wr_en/cfg_index/cfg_wr_data write the window registers; write them
//   only while no request is in flight.
// timing
//   the bitmap sits in 32-bit ram words, one word read per cycle by the scan.
//   allocate: the scan reads k words (1..64), the first at accept, then
//   done. free: read, write-back, done. no-page alloc, empty window and
//   out-of-range free: straight to done. one request in flight; the next is
//   taken once the result is handed to the output register, so a stalled
//   receiver holds one finished result as the next is taken and worked on.
// reset
//   aresetn low clears control state; afterwards a clearing pass writes every
//   ram word to zero, ceil(SLOT_COUNT/32) words (64 at 2048 slots), with
//   s_ready low. configuration writes are taken during the pass.
// ----------------------------------------------------------------------------
module swap_slot_allocator_top
    import ssa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_op,
    input  logic [ENTRY_W-1:0]      s_entry_word,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [SLOT_FIELD_W-1:0] m_slot,
    output logic [STATUS_W-1:0]     m_status,

    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_wr_data
);

`include "swap_slot_allocator_top_assert.svh"

    localparam int WORDS   = (SLOT_COUNT + WORD_W - 1) / WORD_W;
    localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [ENTRY_SLOT_W-1:0] SLOT_LIM  = ENTRY_SLOT_W'(SLOT_COUNT);
    localparam logic [CFG_W-1:0]        SLOT_LAST = CFG_W'(SLOT_COUNT - 1);
    localparam logic [WORD_AW-1:0]      WORD_LAST = WORD_AW'(WORDS - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_FREEW = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [WORD_AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [CFG_W-1:0]        lowest_reg, lowest_next;
    logic [CFG_W-1:0]        highest_reg, highest_next;
    logic                    m_valid_reg, m_valid_next;

    logic [WORD_AW-1:0]      word_reg, word_next;
    logic                    first_reg, first_next;
    logic [BIT_W-1:0]        lo_bit_reg, lo_bit_next;
    logic [WORD_AW-1:0]      last_word_reg, last_word_next;
    logic [BIT_W-1:0]        last_bit_reg, last_bit_next;
    logic [BIT_W-1:0]        bit_reg, bit_next;
    logic [SLOT_FIELD_W-1:0] res_slot_reg, res_slot_next;
    status_t                 res_status_reg, res_status_next;
    logic [SLOT_FIELD_W-1:0] m_slot_reg, m_slot_next;
    status_t                 m_status_reg, m_status_next;

    logic                    ram_we, ram_re;
    logic [WORD_AW-1:0]      ram_waddr, ram_raddr;
    logic [WORD_W-1:0]       ram_wdata, ram_rdata;

    logic [BIT_W-1:0]        ffz_lo, ffz_hi;
    ffz_res_t                ffz;

    logic                    accept;
    logic                    has_page;
    logic [ENTRY_SLOT_W-1:0] entry_slot;
    logic                    free_in_range;
    logic [CFG_W-1:0]        last_sel;
    logic                    window_empty;
    logic                    at_last_word;
    logic                    out_free;

    ssa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ssa_ffz u_ffz (
        .word   (ram_rdata),
        .lo_bit (ffz_lo),
        .hi_bit (ffz_hi),
        .res    (ffz)
    );

    assign s_ready       = (state_reg == S_IDLE);
    assign accept        = s_valid && s_ready;
    assign has_page      = |s_entry_word[ENTRY_W-1:PAGE_LSB];
    assign entry_slot    = s_entry_word[ENTRY_W-1:PAGE_LSB];
    assign free_in_range = entry_slot < SLOT_LIM;
    // search never runs past the end of the map
    assign last_sel      = (ENTRY_SLOT_W'(highest_reg) < SLOT_LIM) ? highest_reg : SLOT_LAST;
    assign window_empty  = lowest_reg > last_sel;
    assign at_last_word  = word_reg == last_word_reg;
    assign out_free      = !m_valid_reg || m_ready;

    assign ffz_lo = first_reg ? lo_bit_reg : '0;
    assign ffz_hi = at_last_word ? last_bit_reg : '1;

    // ram ports
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = word_reg + WORD_AW'(1);
        ram_we    = 1'b0;
        ram_waddr = word_reg;
        ram_wdata = ram_rdata;
        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            S_IDLE: begin
                if (s_op == OP_ALLOC) begin
                    ram_re    = accept && has_page && !window_empty;
                    ram_raddr = WORD_AW'(lowest_reg[CFG_W-1:BIT_W]);
                end else begin
                    ram_re    = accept && free_in_range;
                    ram_raddr = WORD_AW'(entry_slot[ENTRY_SLOT_W-1:BIT_W]);
                end
            end
            S_SCAN: begin
                ram_re    = !ffz.found && !at_last_word;
                ram_we    = ffz.found;
                ram_wdata = ram_rdata | (WORD_W'(1) << ffz.bit_idx);
            end
            S_FREEW: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~(WORD_W'(1) << bit_reg);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        lowest_next     = lowest_reg;
        highest_next    = highest_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        word_next       = word_reg;
        first_next      = first_reg;
        lo_bit_next     = lo_bit_reg;
        last_word_next  = last_word_reg;
        last_bit_next   = last_bit_reg;
        bit_next        = bit_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        m_slot_next     = m_slot_reg;
        m_status_next   = m_status_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LOWEST:  lowest_next  = cfg_wr_data;
                CFG_HIGHEST: highest_next = cfg_wr_data;
                default: begin
                end
            endcase
        end

        case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + WORD_AW'(1);
                if (clr_cnt_reg == WORD_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    res_slot_next = '0;
                    state_next    = S_DONE;
                    if (s_op == OP_ALLOC) begin
                        word_next      = WORD_AW'(lowest_reg[CFG_W-1:BIT_W]);
                        first_next     = 1'b1;
                        lo_bit_next    = lowest_reg[BIT_W-1:0];
                        last_word_next = WORD_AW'(last_sel[CFG_W-1:BIT_W]);
                        last_bit_next  = last_sel[BIT_W-1:0];
                        if (!has_page) begin
                            res_status_next = STAT_NO_PAGE;
                        end else if (window_empty) begin
                            res_status_next = STAT_FULL;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end else begin
                        word_next = WORD_AW'(entry_slot[ENTRY_SLOT_W-1:BIT_W]);
                        bit_next  = entry_slot[BIT_W-1:0];
                        if (free_in_range) begin
                            res_slot_next   = entry_slot[SLOT_FIELD_W-1:0];
                            res_status_next = STAT_FREED;
                            state_next      = S_FREEW;
                        end else begin
                            res_status_next = STAT_RANGE;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (ffz.found) begin
                    res_slot_next   = SLOT_FIELD_W'({word_reg, ffz.bit_idx});
                    res_status_next = STAT_ALLOCATED;
                    state_next      = S_DONE;
                end else if (at_last_word) begin
                    res_slot_next   = '0;
                    res_status_next = STAT_FULL;
                    state_next      = S_DONE;
                end else begin
                    word_next  = word_reg + WORD_AW'(1);
                    first_next = 1'b0;
                end
            end
            S_FREEW: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_slot_next   = res_slot_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            lowest_reg  <= LOWEST_RST;
            highest_reg <= HIGHEST_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            lowest_reg  <= lowest_next;
            highest_reg <= highest_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg       <= word_next;
        first_reg      <= first_next;
        lo_bit_reg     <= lo_bit_next;
        last_word_reg  <= last_word_next;
        last_bit_reg   <= last_bit_next;
        bit_reg        <= bit_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        m_slot_reg     <= m_slot_next;
        m_status_reg   <= m_status_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_slot   = m_slot_reg;
    assign m_status = m_status_reg;

    `SSA_ASSERT_NOW(a_none_slot_zero, aclk, aresetn,
        m_valid && (m_status_reg == STAT_NO_PAGE || m_status_reg == STAT_FULL ||
                    m_status_reg == STAT_RANGE),
        m_slot == '0, "slot not zero on a result without a slot")
    `SSA_ASSERT_NEXT(a_one_in_flight, aclk, aresetn,
        s_valid && s_ready, !s_ready, "second request taken while one is in flight")
    `SSA_ASSERT_NOW(a_write_states, aclk, aresetn,
        ram_we,
        state_reg == S_CLEAR || state_reg == S_SCAN || state_reg == S_FREEW,
        "bitmap written outside clear, scan or free")
    `SSA_ASSERT_NOW(a_result_from_done, aclk, aresetn,
        $rose(m_valid_reg), $past(state_reg) == S_DONE,
        "result raised without a finished request")

endmodule

>>> hw/rtl/ssa_ram.sv
// ----------------------------------------------------------------------------
// ssa_ram
// generic single-clock ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module ssa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/ssa_ffz.sv
// ----------------------------------------------------------------------------
// ssa_ffz
// finds the lowest clear bit of a bitmap word inside a bit window
// ----------------------------------------------------------------------------
module ssa_ffz
    import ssa_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    input  logic [BIT_W-1:0]  lo_bit,
    input  logic [BIT_W-1:0]  hi_bit,
    output ffz_res_t          res
);

    logic [WORD_W-1:0] avail;

    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            avail[i] = !word[i] && (BIT_W'(i) >= lo_bit) && (BIT_W'(i) <= hi_bit);
        end
    end

    // scan from the top so the lowest free bit wins
    always_comb begin
        res = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (avail[i]) begin
                res.found   = 1'b1;
                res.bit_idx = BIT_W'(i);
            end
        end
    end

endmodule

>>> tb/swap_slot_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swap_slot_allocator_top_tb
// self-checking bench for the first-fit swap slot allocator: a bit map
// tracker predicts slot and status per request, results are compared in order
// while both channels idle at random across several search windows
// ----------------------------------------------------------------------------
module swap_slot_allocator_top_tb
    import ssa_pkg::*;
();

    localparam int NUM_SLOTS   = SLOT_COUNT_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        status_t                 status;
    } slot_result_t;

    class slot_allocation_tracker;
        bit           in_use[NUM_SLOTS];
        int           win_lo = int'(LOWEST_RST);
        int           win_hi = int'(HIGHEST_RST);
        slot_result_t due_results[$];
        int           mismatches;
        int           checked;
        int           status_hits[5];

        function void set_window(int lo, int hi);
            win_lo = lo;
            win_hi = hi;
        endfunction

        // a slot currently marked used inside the window, if there is one
        function logic [SLOT_FIELD_W-1:0] pick_used(int lo, int hi);
            int span;
            int start;
            int k;
            int p;
            if (lo > hi) return SLOT_FIELD_W'($urandom_range(0, NUM_SLOTS - 1));
            span  = hi - lo + 1;
            start = $urandom_range(0, span - 1);
            for (k = 0; k < span; k++) begin
                p = lo + (start + k) % span;
                if (in_use[p]) return SLOT_FIELD_W'(p);
            end
            return SLOT_FIELD_W'(lo + start);
        endfunction

        function void note_request(logic op, logic [ENTRY_W-1:0] entry);
            slot_result_t             r;
            logic [ENTRY_SLOT_W-1:0]  pos;
            bit                       found;
            int                       idx;
            r.slot   = '0;
            r.status = STAT_FULL;
            pos      = entry[ENTRY_W-1:PAGE_LSB];
            if (op == OP_ALLOC) begin
                if (pos == '0) begin
                    r.status = STAT_NO_PAGE;
                end else begin
                    found = 1'b0;
                    for (idx = win_lo; idx <= win_hi && idx < NUM_SLOTS && !found; idx++) begin
                        if (!in_use[idx]) begin
                            in_use[idx] = 1'b1;
                            r.slot      = SLOT_FIELD_W'(idx);
                            r.status    = STAT_ALLOCATED;
                            found       = 1'b1;
                        end
                    end
                end
            end else if (pos >= NUM_SLOTS) begin
                r.status = STAT_RANGE;
            end else begin
                in_use[pos] = 1'b0;
                r.slot      = SLOT_FIELD_W'(pos);
                r.status    = STAT_FREED;
            end
            due_results.push_back(r);
        endfunction

        function void report(string what, int expd, int got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on result %0d: %s expected %0d, got %0d",
                         checked, what, expd, got);
        endfunction

        function void check_result(logic [SLOT_FIELD_W-1:0] slot, logic [STATUS_W-1:0] status);
            slot_result_t want;
            if (due_results.size() == 0) begin
                report("unexpected result, status", -1, int'(status));
            end else begin
                want = due_results.pop_front();
                if (slot !== want.slot) report("slot", int'(want.slot), int'(slot));
                if (status !== want.status) report("status", int'(want.status), int'(status));
                if (int'(want.status) < 5) status_hits[int'(want.status)]++;
            end
            checked++;
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn      = 1'b0;
    logic                    s_valid      = 1'b0;
    logic                    s_ready;
    logic                    s_op         = OP_ALLOC;
    logic [ENTRY_W-1:0]      s_entry_word = '0;
    logic                    m_valid;
    logic                    m_ready      = 1'b0;
    logic [SLOT_FIELD_W-1:0] m_slot;
    logic [STATUS_W-1:0]     m_status;
    logic                    cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index    = CFG_LOWEST;
    logic [CFG_W-1:0]        cfg_wr_data  = '0;

    int unsigned             cycle_count  = 0;
    int                      phases_run   = 0;
    slot_allocation_tracker  tracker      = new();

    swap_slot_allocator_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_entry_word (s_entry_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_slot       (m_slot),
        .m_status     (m_status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d results still due",
                 cycle_count, tracker.due_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // mostly short pauses, now and then a long one
    function automatic int pause_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls with recurring calm stretches, one long hold
    initial begin : result_sink
        int hold_left;
        int seen;
        hold_left = 0;
        seen      = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                tracker.check_result(m_slot, m_status);
                seen++;
                if (seen == 200) hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if ((cycle_count % 512) >= 128 && $urandom_range(0, 3) == 0) begin
                hold_left = pause_len() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // valid stays up across back-to-back requests; lowered only ahead of a gap
    task automatic send_request(input logic op, input logic [ENTRY_W-1:0] entry,
                                input bit no_gaps);
        int gap;
        gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : pause_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_entry_word <= entry;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(op, entry);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_window(input int lo, input int hi);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_LOWEST;
        cfg_wr_data <= CFG_W'(lo);
        @(posedge aclk);
        cfg_index   <= CFG_HIGHEST;
        cfg_wr_data <= CFG_W'(hi);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.set_window(lo, hi);
    endtask

    task automatic run_phase(input int lo, input int hi, input int count);
        bit                 no_gaps;
        int                 r;
        int                 n;
        logic               op;
        logic [ENTRY_W-1:0] entry;
        write_window(lo, hi);
        phases_run++;
        no_gaps = ($urandom_range(0, 3) == 0);
        for (n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                op    = OP_ALLOC;
                entry = $urandom;
                if (entry[ENTRY_W-1:PAGE_LSB] == '0)
                    entry[$urandom_range(PAGE_LSB, ENTRY_W - 1)] = 1'b1;
            end else if (r < 80) begin
                op    = OP_FREE;
                entry = (ENTRY_W'(tracker.pick_used(lo, hi)) << PAGE_LSB) | ($urandom & 32'hfff);
            end else if (r < 87) begin
                op    = OP_FREE;
                entry = (ENTRY_W'($urandom_range(0, NUM_SLOTS - 1)) << PAGE_LSB)
                        | ($urandom & 32'hfff);
            end else if (r < 91) begin
                op    = OP_ALLOC;
                entry = $urandom & 32'hfff;
            end else if (r < 95) begin
                // slot field past the end of the map
                op    = OP_FREE;
                entry = $urandom | (32'h1 << $urandom_range(23, 31));
            end else begin
                op    = 1'($urandom);
                entry = $urandom;
            end
            send_request(op, entry, no_gaps);
        end
        drain();
    endtask

    initial begin : stimulus
        int lo;
        int hi;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed requests under the reset window
        send_request(OP_ALLOC, 32'h0000_0000, 1'b0);  // no page given
        send_request(OP_ALLOC, 32'h0000_0fff, 1'b0);  // no page, low bits set
        send_request(OP_ALLOC, 32'hffff_ffff, 1'b0);
        send_request(OP_ALLOC, 32'h0000_1000, 1'b0);
        send_request(OP_ALLOC, 32'h8000_0000, 1'b0);
        send_request(OP_FREE,  32'h0000_1000, 1'b0);
        send_request(OP_FREE,  32'h0000_1fff, 1'b0);  // already free
        send_request(OP_ALLOC, 32'h1234_5678, 1'b0);  // refills the hole
        send_request(OP_FREE,  32'h0000_0000, 1'b0);
        send_request(OP_FREE,  32'hffff_ffff, 1'b0);  // out of range
        send_request(OP_FREE,  32'h0080_0000, 1'b0);  // first slot past the map
        send_request(OP_FREE,  32'h007f_f000, 1'b0);  // last slot, never used
        send_request(OP_ALLOC, 32'hffff_f000, 1'b0);
        send_request(OP_FREE,  32'h007f_ffff, 1'b0);
        send_request(OP_FREE,  32'h0000_2abc, 1'b0);
        send_request(OP_FREE,  32'h0000_3000, 1'b0);
        drain();

        run_phase(3, 12, 60);        // small window fills up
        run_phase(2047, 2047, 30);   // top slot only
        run_phase(0, 0, 30);         // bottom slot only
        run_phase(100, 50, 25);      // empty window
        run_phase(0, 2047, 80);
        repeat (4) begin
            lo = $urandom_range(0, NUM_SLOTS - 1);
            hi = lo + $urandom_range(0, 40);
            if (hi > NUM_SLOTS - 1) hi = NUM_SLOTS - 1;
            run_phase(lo, hi, 50);
        end

        repeat (20) @(posedge aclk);
        $display("%0d results checked over %0d window settings plus directed requests",
                 tracker.checked, phases_run);
        $display("allocated %0d, no page %0d, full %0d, freed %0d, out of range %0d",
                 tracker.status_hits[STAT_ALLOCATED], tracker.status_hits[STAT_NO_PAGE],
                 tracker.status_hits[STAT_FULL], tracker.status_hits[STAT_FREED],
                 tracker.status_hits[STAT_RANGE]);
        if (tracker.mismatches > 10)
            $display("%0d mismatches in total", tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (tracker.due_results.size() != 0)
                $display("%0d results never arrived", tracker.due_results.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
